[hw/rtl/opfr_pkg.sv]
// Shared types and constants for the OLED page framebuffer refresh block.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package opfr_pkg;

  localparam int COLUMNS_DEFAULT = 128;
  localparam int PAGES_DEFAULT   = 8;

  // Position of the first column byte inside one page's stream.
  localparam int DATA_FIRST = 11;

  localparam logic [1:0] KIND_DRAW    = 2'd0;
  localparam logic [1:0] KIND_CLEAR   = 2'd1;
  localparam logic [1:0] KIND_REFRESH = 2'd2;

  // Register index codes (paddr[2]).
  localparam logic REG_DEV_ADDR = 1'b0;

  localparam logic [7:0] DEV_ADDR_RESET = 8'h78;
  localparam logic [7:0] CTRL_CMD       = 8'h00;
  localparam logic [7:0] CTRL_DATA      = 8'h40;
  localparam logic [7:0] CMD_PAGE_BASE  = 8'hB0;
  localparam logic [7:0] CMD_COL_LO     = 8'h00;
  localparam logic [7:0] CMD_COL_HI     = 8'h10;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic       pixel_on;
  } item_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       start_before;
    logic       stop_after;
    logic       pixel_payload;
    logic       frame_done;
  } result_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;   // capture the item and read the store
    logic exec;   // finish a draw or refresh word
    logic clr;    // write one zero of the clearing sweep
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_last;  // the sweep writes its last entry this cycle
  } status_t;

endpackage

`default_nettype wire

[hw/rtl/oled_page_framebuffer_refresh_top.sv]
// Top level of the OLED page framebuffer refresh block: APB register,
// controller and datapath. Depends on opfr_pkg, opfr_ctrl, opfr_datapath.
//
//   Channel   Signals                              Direction  Handshake
//   item      start, busy, item                    in         start && !busy
//   result    result_valid, result                 out        one-cycle strobe
//   config    psel penable pwrite paddr pwdata     in         APB, pready high
//
// A draw or refresh word keeps busy high for one cycle after it is accepted,
// so no new word is taken until that cycle ends; a refresh result shows on the
// cycle after that, set by the registered read of the single-port store.
// A clear word and reset both run a sweep that writes one zero per cycle over
// the COLUMNS*PAGES entries (1024 entries at the defaults) with busy high.
// The receiver cannot stall: each result stands for exactly one cycle.
`default_nettype none

module oled_page_framebuffer_refresh_top #(
  parameter int COLUMNS = opfr_pkg::COLUMNS_DEFAULT,
  parameter int PAGES   = opfr_pkg::PAGES_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire opfr_pkg::item_t   item,
  output logic                   result_valid,
  output opfr_pkg::result_t      result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  opfr_pkg::cmd_t    cmd;
  opfr_pkg::status_t status;
  logic [7:0]        dev_addr;
  logic              reg_hit;

  // Only the device address register exists; paddr[2] selects it.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == opfr_pkg::REG_DEV_ADDR) && (paddr[1:0] == 2'b00);
  assign prdata  = reg_hit ? {24'h0, dev_addr} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr <= opfr_pkg::DEV_ADDR_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == opfr_pkg::REG_DEV_ADDR) begin
      dev_addr <= pwdata[7:0];
    end
  end

  opfr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (item.kind),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  opfr_datapath #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .item         (item),
    .dev_addr     (dev_addr),
    .status       (status),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

`default_nettype wire

[hw/rtl/opfr_ctrl.sv]
// Controller state machine of the OLED page framebuffer refresh block.
// Depends on opfr_pkg for the item, command and status types.
`default_nettype none

module opfr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [1:0]        kind,
  input  wire opfr_pkg::status_t status,
  output logic                   busy,
  output opfr_pkg::cmd_t         cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign busy     = (state != ST_IDLE);
  assign cmd.load = start && !busy;
  assign cmd.exec = (state == ST_EXEC);
  assign cmd.clr  = (state == ST_CLEAR);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.load) begin
          state_next = (kind == opfr_pkg::KIND_CLEAR) ? ST_CLEAR : ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      ST_CLEAR: begin
        if (status.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Reset starts a clearing sweep so the store reads as all zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/opfr_datapath.sv]
// Datapath of the OLED page framebuffer refresh block: frame store memory,
// refresh stream counters, clearing sweep and result register. Uses opfr_pkg.
`default_nettype none

module opfr_datapath #(
  parameter int COLUMNS = opfr_pkg::COLUMNS_DEFAULT,
  parameter int PAGES   = opfr_pkg::PAGES_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire opfr_pkg::cmd_t    cmd,
  input  wire opfr_pkg::item_t   item,
  input  wire logic [7:0]        dev_addr,
  output opfr_pkg::status_t      status,
  output opfr_pkg::result_t      result,
  output logic                   result_valid
);

  localparam int STORE   = COLUMNS * PAGES;
  localparam int ADDR_W  = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int PAGE_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int POS_LEN = COLUMNS + opfr_pkg::DATA_FIRST;
  localparam int POS_W   = $clog2(POS_LEN);
  localparam int ROWS    = 8 * PAGES;

  logic [7:0] mem [STORE];
  logic [7:0] rd_data;

  opfr_pkg::item_t item_q;
  logic            in_range_q;

  logic [PAGE_W-1:0] page;
  logic [POS_W-1:0]  pos;
  logic [ADDR_W-1:0] clr_addr;

  logic [15:0]       draw_sum;
  logic [15:0]       fetch_sum;
  logic [15:0]       pos16;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [7:0]        mem_wd;
  logic [7:0]        mask;
  opfr_pkg::result_t res_next;

  assign pos16     = 16'(pos);
  assign draw_sum  = 16'(item.pixel_y[7:3]) * 16'(COLUMNS) + 16'(item.pixel_x);
  assign fetch_sum = 16'(page) * 16'(COLUMNS) + pos16 - 16'(opfr_pkg::DATA_FIRST);
  assign rd_addr   = (item.kind == opfr_pkg::KIND_DRAW) ? draw_sum[ADDR_W-1:0]
                                                        : fetch_sum[ADDR_W-1:0];
  assign mask      = 8'(1) << item_q.pixel_y[2:0];

  assign status.clr_last = (clr_addr == ADDR_W'(STORE - 1));

  // The draw address is recomputed from the held item during the write cycle.
  logic [15:0] draw_sum_q;
  assign draw_sum_q = 16'(item_q.pixel_y[7:3]) * 16'(COLUMNS) + 16'(item_q.pixel_x);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_addr;
    mem_wd = 8'h00;
    if (cmd.clr) begin
      mem_we = 1'b1;
    end else if (cmd.exec && item_q.kind == opfr_pkg::KIND_DRAW && in_range_q) begin
      mem_we = 1'b1;
      mem_wa = draw_sum_q[ADDR_W-1:0];
      mem_wd = item_q.pixel_on ? (rd_data | mask) : (rd_data & ~mask);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.load) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Stream byte for the current position: three command transactions,
  // then the data transaction header and the column bytes.
  always_comb begin
    res_next = '0;
    if (pos16 == 16'd0 || pos16 == 16'd3 || pos16 == 16'd6 || pos16 == 16'd9) begin
      res_next.bus_byte     = dev_addr;
      res_next.start_before = 1'b1;
    end else if (pos16 == 16'd1 || pos16 == 16'd4 || pos16 == 16'd7) begin
      res_next.bus_byte = opfr_pkg::CTRL_CMD;
    end else if (pos16 == 16'd2) begin
      res_next.bus_byte   = opfr_pkg::CMD_PAGE_BASE + 8'(page);
      res_next.stop_after = 1'b1;
    end else if (pos16 == 16'd5) begin
      res_next.bus_byte   = opfr_pkg::CMD_COL_LO;
      res_next.stop_after = 1'b1;
    end else if (pos16 == 16'd8) begin
      res_next.bus_byte   = opfr_pkg::CMD_COL_HI;
      res_next.stop_after = 1'b1;
    end else if (pos16 == 16'd10) begin
      res_next.bus_byte = opfr_pkg::CTRL_DATA;
    end else begin
      res_next.bus_byte      = rd_data;
      res_next.pixel_payload = 1'b1;
      if (pos == POS_W'(POS_LEN - 1)) begin
        res_next.stop_after = 1'b1;
        res_next.frame_done = (page == PAGE_W'(PAGES - 1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q     <= item;
      in_range_q <= (item.pixel_x < 8'(COLUMNS)) && (item.pixel_y < 8'(ROWS));
    end
    if (cmd.exec) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page         <= '0;
      pos          <= '0;
      clr_addr     <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.exec && (item_q.kind == opfr_pkg::KIND_REFRESH);
      if (cmd.exec && item_q.kind == opfr_pkg::KIND_REFRESH) begin
        if (pos == POS_W'(POS_LEN - 1)) begin
          pos  <= '0;
          page <= (page == PAGE_W'(PAGES - 1)) ? '0 : page + PAGE_W'(1);
        end else begin
          pos <= pos + POS_W'(1);
        end
      end
      if (cmd.clr) begin
        clr_addr <= status.clr_last ? '0 : clr_addr + ADDR_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[dv/oled_page_framebuffer_refresh_top_tb.sv]
// Self-checking testbench for the OLED page framebuffer refresh block.
// Depends on opfr_pkg and oled_page_framebuffer_refresh_top; nothing else.
// A shadow framebuffer and refresh-stream position predict every bus word.
`default_nettype none

module oled_page_framebuffer_refresh_top_tb;
  import opfr_pkg::*;

  localparam int COLS = COLUMNS_DEFAULT;
  localparam int PGS  = PAGES_DEFAULT;
  localparam int ROWS = PGS * 8;
  localparam int PAGE_WORDS = DATA_FIRST + COLS;

  // Kind code that the block must ignore.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Byte addresses of the device address register and of the unused slot.
  localparam logic [2:0] ADDR_DEV   = {REG_DEV_ADDR, 2'b00};
  localparam logic [2:0] ADDR_SPARE = {~REG_DEV_ADDR, 2'b00};

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 4;  // a draw or clear start may still be in flight
  localparam int TAIL_CYCLES = 8;
  localparam int PHASE_ITEMS = 150;

  typedef struct {
    item_t   w;
    bit      typed;
    result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  item_t       item = '0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic        busy;
  logic        result_valid;
  result_t     result;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the block's state.
  logic [7:0]  shadow_fb [COLS*PGS];
  int unsigned stream_page;
  int unsigned stream_pos;
  logic [7:0]  shadow_dev_addr;

  result_t     bytes_due [$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          no_idle = 1'b0;

  oled_page_framebuffer_refresh_top #(
    .COLUMNS(COLS),
    .PAGES  (PGS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .result_valid(result_valid),
    .result      (result),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Apply one accepted word to the shadow state. A refresh word yields the
  // next byte of the stream; draw, clear and the unused kind yield nothing.
  task automatic advance_panel_model(input item_t w, output bit produced,
                                     output result_t r);
    int unsigned col;
    int idx;
    produced = 1'b0;
    r = '0;
    case (w.kind)
      KIND_DRAW: begin
        // Coordinates off the panel are dropped.
        if (w.pixel_x < COLS && w.pixel_y < ROWS) begin
          idx = int'(w.pixel_y >> 3) * COLS + int'(w.pixel_x);
          shadow_fb[idx][w.pixel_y[2:0]] = w.pixel_on;
        end
      end
      KIND_CLEAR: begin
        // The stream position survives a clear; later data reads zeros.
        foreach (shadow_fb[i]) shadow_fb[i] = '0;
      end
      KIND_REFRESH: begin
        produced = 1'b1;
        if (stream_pos < DATA_FIRST - 2) begin
          // Three command transactions: address, control, command.
          case (stream_pos % 3)
            0: begin
              r.bus_byte = shadow_dev_addr;
              r.start_before = 1'b1;
            end
            1: r.bus_byte = CTRL_CMD;
            default: begin
              case (stream_pos / 3)
                0: r.bus_byte = CMD_PAGE_BASE + 8'(stream_page);
                1: r.bus_byte = CMD_COL_LO;
                default: r.bus_byte = CMD_COL_HI;
              endcase
              r.stop_after = 1'b1;
            end
          endcase
        end else if (stream_pos == DATA_FIRST - 2) begin
          r.bus_byte = shadow_dev_addr;
          r.start_before = 1'b1;
        end else if (stream_pos == DATA_FIRST - 1) begin
          r.bus_byte = CTRL_DATA;
        end else begin
          col = stream_pos - DATA_FIRST;
          r.bus_byte = shadow_fb[stream_page * COLS + col];
          r.pixel_payload = 1'b1;
          if (col == COLS - 1) begin
            r.stop_after = 1'b1;
            if (stream_page == PGS - 1) begin
              r.frame_done = 1'b1;
            end
          end
        end
        stream_pos++;
        if (stream_pos >= PAGE_WORDS) begin
          stream_pos = 0;
          stream_page = (stream_page + 1 >= PGS) ? 0 : stream_page + 1;
        end
      end
      default: ;
    endcase
  endtask

  // Offer one word after a random gap; start is left high on return so that
  // a following word with no gap keeps it high without a glitch.
  task automatic send_word(input item_t w, input bit typed, input result_t want);
    int gap;
    bit produced;
    result_t r;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    advance_panel_model(w, produced, r);
    if (produced) bytes_due.push_back(typed ? want : r);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (bytes_due.size() != 0) @(posedge clk);
  endtask

  // Registers change only with the block idle: no byte owed, no draw
  // finishing, and no clearing sweep under way.
  task automatic settle_for_config();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_DEV) shadow_dev_addr = data[7:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_dev_addr();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_DEV;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[7:0] !== shadow_dev_addr) begin
      $error("device_address_byte: expected %h, got %h", shadow_dev_addr, prdata[7:0]);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic stim_row_t mk(input logic [1:0] k, input logic [7:0] x,
                                   input logic [7:0] y, input logic on,
                                   input bit typed, input result_t want);
    stim_row_t row;
    row.w.kind = k;
    row.w.pixel_x = x;
    row.w.pixel_y = y;
    row.w.pixel_on = on;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  // Every bus word is checked, field by field, against the oldest one owed.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (bytes_due.size() == 0) begin
        $error("unexpected bus word %h", result);
        mismatches++;
      end else begin
        want = bytes_due.pop_front();
        if (result.bus_byte !== want.bus_byte) begin
          $error("bus_byte: expected %h, got %h", want.bus_byte, result.bus_byte);
          mismatches++;
        end
        if (result.start_before !== want.start_before) begin
          $error("start_before: expected %b, got %b", want.start_before,
                 result.start_before);
          mismatches++;
        end
        if (result.stop_after !== want.stop_after) begin
          $error("stop_after: expected %b, got %b", want.stop_after, result.stop_after);
          mismatches++;
        end
        if (result.pixel_payload !== want.pixel_payload) begin
          $error("pixel_payload: expected %b, got %b", want.pixel_payload,
                 result.pixel_payload);
          mismatches++;
        end
        if (result.frame_done !== want.frame_done) begin
          $error("frame_done: expected %b, got %b", want.frame_done, result.frame_done);
          mismatches++;
        end
      end
    end
  end

  initial begin
    stim_row_t rows [$];
    item_t w;
    int n;
    int ph;
    int roll;
    logic [7:0] phase_addr;

    foreach (shadow_fb[i]) shadow_fb[i] = '0;
    stream_page = 0;
    stream_pos = 0;
    shadow_dev_addr = DEV_ADDR_RESET;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // The register must come out of reset at its default.
    settle_for_config();
    check_dev_addr();

    // Directed part: the opening words of the stream, the coordinate edges,
    // a set then clear of one bit, the unused kind, and a clear mid-stream.
    rows.push_back(mk(KIND_REFRESH, 8'h00, 8'h00, 1'b0, 1'b1,
                      result_t'({DEV_ADDR_RESET, 1'b1, 1'b0, 1'b0, 1'b0})));
    rows.push_back(mk(KIND_REFRESH, 8'hFF, 8'hFF, 1'b1, 1'b1,
                      result_t'({CTRL_CMD, 1'b0, 1'b0, 1'b0, 1'b0})));
    rows.push_back(mk(KIND_REFRESH, 8'h00, 8'h00, 1'b0, 1'b1,
                      result_t'({CMD_PAGE_BASE, 1'b0, 1'b1, 1'b0, 1'b0})));
    rows.push_back(mk(KIND_DRAW, 8'd0, 8'd0, 1'b1, 1'b0, '0));
    rows.push_back(mk(KIND_DRAW, 8'(COLS - 1), 8'(ROWS - 1), 1'b1, 1'b0, '0));
    rows.push_back(mk(KIND_DRAW, 8'(COLS), 8'd0, 1'b1, 1'b0, '0));
    rows.push_back(mk(KIND_DRAW, 8'd0, 8'(ROWS), 1'b1, 1'b0, '0));
    rows.push_back(mk(KIND_DRAW, 8'hFF, 8'hFF, 1'b1, 1'b0, '0));
    rows.push_back(mk(KIND_DRAW, 8'd1, 8'd7, 1'b1, 1'b0, '0));
    rows.push_back(mk(KIND_DRAW, 8'd1, 8'd7, 1'b0, 1'b0, '0));
    rows.push_back(mk(KIND_DRAW, 8'd1, 8'd6, 1'b1, 1'b0, '0));
    rows.push_back(mk(KIND_UNUSED, 8'hFF, 8'hFF, 1'b1, 1'b0, '0));
    repeat (7) rows.push_back(mk(KIND_REFRESH, 8'h5A, 8'hA5, 1'b0, 1'b0, '0));
    rows.push_back(mk(KIND_REFRESH, 8'h00, 8'h00, 1'b0, 1'b1,
                      result_t'({CTRL_DATA, 1'b0, 1'b0, 1'b0, 1'b0})));
    rows.push_back(mk(KIND_REFRESH, 8'h00, 8'h00, 1'b0, 1'b0, '0));
    rows.push_back(mk(KIND_REFRESH, 8'h00, 8'h00, 1'b0, 1'b0, '0));
    rows.push_back(mk(KIND_CLEAR, 8'hFF, 8'hFF, 1'b1, 1'b0, '0));
    rows.push_back(mk(KIND_REFRESH, 8'h00, 8'h00, 1'b0, 1'b0, '0));
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].want);

    // Random part in phases, one device address each, extremes first.
    for (ph = 0; ph < 4; ph++) begin
      settle_for_config();
      case (ph)
        0: phase_addr = 8'h00;
        1: phase_addr = 8'hFF;
        default: phase_addr = 8'($urandom_range(1, 254));
      endcase
      if (ph == 1) write_reg(ADDR_SPARE, $urandom());
      write_reg(ADDR_DEV, {24'($urandom()), phase_addr});
      check_dev_addr();

      n = 0;
      while (n < PHASE_ITEMS) begin
        if (n % 32 == 0) no_idle = ($urandom_range(0, 3) == 0);
        w.pixel_x = 8'($urandom_range(0, 255));
        w.pixel_y = 8'($urandom_range(0, 255));
        w.pixel_on = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          w.kind = KIND_REFRESH;
        end else if (roll < 95) begin
          w.kind = KIND_DRAW;
          // Mostly on-panel draws, so that data bytes carry real content.
          if ($urandom_range(0, 9) != 0) begin
            w.pixel_x = 8'($urandom_range(0, COLS - 1));
            w.pixel_y = 8'($urandom_range(0, ROWS - 1));
          end
        end else if (roll < 96) begin
          w.kind = KIND_CLEAR;
        end else begin
          w.kind = KIND_UNUSED;
        end
        send_word(w, 1'b0, '0);
        if (w.kind != KIND_UNUSED) n++;
        // Now and then hold off until every owed byte has shown.
        if ($urandom_range(0, 63) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (bytes_due.size() != 0) begin
      $error("%0d bus words never arrived", bytes_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
